// ===== rtl/core/fqr_pkg.sv =====
// ----------------------------------------------------------------------------
// fqr_pkg
// Shared types and constants for the FIFO queue with remove-at-index.
// ----------------------------------------------------------------------------
package fqr_pkg;

   localparam int KIND_W   = 2;
   localparam int ID_W     = 32;
   localparam int NAME_W   = 64;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int ENTRY_W  = ID_W + NAME_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD   = 2'd0,
      KIND_SERVE = 2'd1,
      KIND_LEAVE = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BOUNDS = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_CAPTURE,
      S_SHIFT,
      S_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       latch;        // take the request fields
      logic       set_status;   // load status code, clear removed entry
      status_type status_code;
      logic       append;       // write request at tail, grow count
      logic       rd_start;     // read the entry to remove, cursor to it
      logic       capture;      // keep the removed entry, read cursor + 1
      logic       shift;        // move read entry down one slot, read cursor + 2
      logic       shrink;       // drop count by one
      logic       publish;      // load the result register
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     full;
      logic     empty;
      logic     pos_oob;
      logic     more_one;       // cursor + 1 still below count
      logic     more_two;       // cursor + 2 still below count
      logic     out_free;       // result register can take a new transaction
   } ctl_sts_type;

endpackage

// ===== rtl/core/fqr_ram.sv =====
// ----------------------------------------------------------------------------
// fqr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fqr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/core/fqr_ctrl.sv =====
// ----------------------------------------------------------------------------
// fqr_ctrl
// Sequencer for add, serve and remove-at-position, including the compaction
// loop that closes the gap after a removal.
// ----------------------------------------------------------------------------
module fqr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fqr_pkg::ctl_sts_type sts,
   output fqr_pkg::ctl_cmd_type cmd
);
   import fqr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_OK;
            state_in        = S_FINISH;
            unique case (sts.kind)
               KIND_ADD: begin
                  if (sts.full) begin
                     cmd.status_code = ST_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               KIND_SERVE: begin
                  if (sts.empty) begin
                     cmd.status_code = ST_EMPTY;
                  end else begin
                     cmd.rd_start = 1'b1;
                     state_in     = S_CAPTURE;
                  end
               end
               KIND_LEAVE: begin
                  priority if (sts.empty) begin
                     cmd.status_code = ST_EMPTY;
                  end else if (sts.pos_oob) begin
                     cmd.status_code = ST_BOUNDS;
                  end else begin
                     cmd.rd_start = 1'b1;
                     state_in     = S_CAPTURE;
                  end
               end
               KIND_NONE: begin
                  cmd.status_code = ST_OK;
               end
               default: begin
                  cmd.status_code = ST_OK;
               end
            endcase
         end
         S_CAPTURE: begin
            cmd.capture = 1'b1;
            if (sts.more_one) begin
               state_in = S_SHIFT;
            end else begin
               cmd.shrink = 1'b1;
               state_in   = S_FINISH;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (!sts.more_two) begin
               cmd.shrink = 1'b1;
               state_in   = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/fqr_dp.sv =====
// ----------------------------------------------------------------------------
// fqr_dp
// Datapath: request capture, entry count, compaction cursor, entry store
// and the result register.
// ----------------------------------------------------------------------------
module fqr_dp #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fqr_pkg::ctl_cmd_type          cmd,
   output fqr_pkg::ctl_sts_type          sts,
   input  logic [fqr_pkg::KIND_W-1:0]    req_kind,
   input  logic [fqr_pkg::ID_W-1:0]      req_entry_id,
   input  logic [fqr_pkg::NAME_W-1:0]    req_entry_name,
   input  logic [fqr_pkg::POS_W-1:0]     req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fqr_pkg::STATUS_W-1:0]  rsp_status,
   output logic [fqr_pkg::ID_W-1:0]      rsp_removed_id,
   output logic [fqr_pkg::NAME_W-1:0]    rsp_removed_name,
   output logic [fqr_pkg::COUNT_W-1:0]   rsp_entry_count
);
   import fqr_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int OW = $clog2(QUEUE_DEPTH + 1);
   localparam int CW = (OW > POS_W) ? OW : POS_W;
   localparam int XW = (OW > COUNT_W) ? OW : COUNT_W;

   kind_type          kind_ff;
   logic [ID_W-1:0]   id_ff;
   logic [NAME_W-1:0] name_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [OW-1:0]     occ_ff;
   logic [OW-1:0]     cursor_ff;
   status_type        status_ff;
   logic [ID_W-1:0]   rem_id_ff;
   logic [NAME_W-1:0] rem_name_ff;
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   logic [NAME_W-1:0] rsp_name_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic [CW-1:0]      pos_wide;
   logic [CW-1:0]      occ_cmp;
   logic [XW-1:0]      occ_wide;
   logic [OW:0]        cursor_p1;
   logic [OW:0]        cursor_p2;
   logic [OW-1:0]      start_idx;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   assign pos_wide  = CW'(pos_ff);
   assign occ_cmp   = CW'(occ_ff);
   assign occ_wide  = XW'(occ_ff);
   assign cursor_p1 = {1'b0, cursor_ff} + (OW+1)'(1);
   assign cursor_p2 = {1'b0, cursor_ff} + (OW+1)'(2);
   // serve takes the head; a leave position has passed the bounds check
   assign start_idx = (kind_ff == KIND_SERVE) ? '0 : pos_wide[OW-1:0];

   assign sts.kind     = kind_ff;
   assign sts.full     = (occ_ff == OW'(QUEUE_DEPTH));
   assign sts.empty    = (occ_ff == '0);
   assign sts.pos_oob  = (pos_wide >= occ_cmp);
   assign sts.more_one = (cursor_p1 < {1'b0, occ_ff});
   assign sts.more_two = (cursor_p2 < {1'b0, occ_ff});
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ram_we    = cmd.append || cmd.shift;
      ram_waddr = cmd.append ? occ_ff[AW-1:0] : cursor_ff[AW-1:0];
      ram_wdata = cmd.append ? {id_ff, name_ff} : ram_rdata;
      priority if (cmd.rd_start) begin
         ram_raddr = start_idx[AW-1:0];
      end else if (cmd.capture) begin
         ram_raddr = cursor_p1[AW-1:0];
      end else begin
         ram_raddr = cursor_p2[AW-1:0];
      end
   end

   fqr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.append) begin
            occ_ff <= occ_ff + OW'(1);
         end else if (cmd.shrink) begin
            occ_ff <= occ_ff - OW'(1);
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= kind_type'(req_kind);
         id_ff   <= req_entry_id;
         name_ff <= req_entry_name;
         pos_ff  <= req_position;
      end
      if (cmd.set_status) begin
         status_ff   <= cmd.status_code;
         rem_id_ff   <= '0;
         rem_name_ff <= '0;
      end
      if (cmd.rd_start) begin
         cursor_ff <= start_idx;
      end else if (cmd.shift) begin
         cursor_ff <= cursor_p1[OW-1:0];
      end
      if (cmd.capture) begin
         rem_id_ff   <= ram_rdata[ENTRY_W-1:NAME_W];
         rem_name_ff <= ram_rdata[NAME_W-1:0];
      end
      if (cmd.publish) begin
         rsp_status_ff <= status_ff;
         rsp_id_ff     <= rem_id_ff;
         rsp_name_ff   <= rem_name_ff;
         rsp_count_ff  <= occ_wide[COUNT_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_removed_id   = rsp_id_ff;
   assign rsp_removed_name = rsp_name_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule

// ===== rtl/core/fifo_queue_remove_at_index.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_remove_at_index
// Add, unused kind and errors: the request is latched and decided, and the result
// is loaded once the result register is free. Serve or removal at position p
// (serve is p = 0): the entry at p is read and captured, then one entry behind it
// moves down per cycle in the single-port-write store until the gap is closed.
// One transaction at a time; the next request can be taken in the cycle after
// the result is loaded. Reset empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
module fifo_queue_remove_at_index #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fqr_pkg::KIND_W-1:0]    req_kind,
   input  logic [fqr_pkg::ID_W-1:0]      req_entry_id,
   input  logic [fqr_pkg::NAME_W-1:0]    req_entry_name,
   input  logic [fqr_pkg::POS_W-1:0]     req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fqr_pkg::STATUS_W-1:0]  rsp_status,
   output logic [fqr_pkg::ID_W-1:0]      rsp_removed_id,
   output logic [fqr_pkg::NAME_W-1:0]    rsp_removed_name,
   output logic [fqr_pkg::COUNT_W-1:0]   rsp_entry_count
);
   import fqr_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   fqr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fqr_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_kind         (req_kind),
      .req_entry_id     (req_entry_id),
      .req_entry_name   (req_entry_name),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_removed_id   (rsp_removed_id),
      .rsp_removed_name (rsp_removed_name),
      .rsp_entry_count  (rsp_entry_count)
   );

   // never write past the tail of a full queue
   assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> !sts.full)
      else $error("append issued on a full queue");

   // an error result carries no removed entry
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_removed_id == '0 && rsp_removed_name == '0))
      else $error("error result with nonzero removed entry");

   // one transaction in flight: no request taken right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous one still in work");

   // a result is only loaded when the output register is free
   assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten before it was taken");

endmodule
